/* sv/phf_pkg.sv */
// Shared constants, types and helpers for the periodic subregion halo filter.
package phf_pkg;

  // Fraction bits of positions, centers and widths.
  localparam int FRAC_BITS = 24;
  // Signed image width, Q1.FRAC_BITS.
  localparam int IMG_W = FRAC_BITS + 2;
  localparam int IDX_W = 32;
  localparam int CFG_IDX_W = 3;

  // Small front-to-back queue.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // 2x2x2 image visit order: bit a of the mask is image a, x slowest.
  localparam int N_IMG = 8;
  localparam logic [N_IMG-1:0] MASK_MAIN = N_IMG'(1);
  localparam logic [N_IMG-1:0] SHIFT_X_SET = 8'hF0;
  localparam logic [N_IMG-1:0] SHIFT_Y_SET = 8'hCC;
  localparam logic [N_IMG-1:0] SHIFT_Z_SET = 8'hAA;

  // Fixed-point constants.
  localparam logic signed [IMG_W-1:0] ONE_S = signed'(IMG_W'(1) << FRAC_BITS);
  localparam logic signed [IMG_W-1:0] HALF_S = signed'(IMG_W'(1) << (FRAC_BITS - 1));
  localparam logic [FRAC_BITS-1:0] HALF_U = FRAC_BITS'(64'd1 << (FRAC_BITS - 1));
  // 1/2 plus a 0.1 border, truncated.
  localparam logic [FRAC_BITS-1:0] HTW_RST =
    FRAC_BITS'((64'd1 << (FRAC_BITS - 1)) + ((64'd1 << FRAC_BITS) / 10));

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_W = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_TW = 3'd4;

  // One classified particle: wrapped offsets, shifted offsets, images to emit.
  typedef struct packed {
    logic signed [IMG_W-1:0] dx;
    logic signed [IMG_W-1:0] dy;
    logic signed [IMG_W-1:0] dz;
    logic signed [IMG_W-1:0] sx;
    logic signed [IMG_W-1:0] sy;
    logic signed [IMG_W-1:0] sz;
    logic in_main;
    logic [N_IMG-1:0] mask;
    logic [IDX_W-1:0] index;
  } phf_entry_t;

endpackage

/* sv/periodic_subregion_halo_filter.sv */
// Top level of the periodic subregion halo filter.
// The first result word passes the stage 1 register, the queue and the output word register.
// Throughput: one particle per cycle in while full is low; one result word per cycle out
// while pop is high, k buffer images giving k words; a 4-particle queue absorbs bursts.
// Reset (rst, synchronous, active high) empties all queues, zeroes the particle index
// and loads center 1/2, half width 1/2 and buffered half width 0.6 on every axis.
module periodic_subregion_halo_filter import phf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [FRAC_BITS-1:0] pos_x,
  input  logic [FRAC_BITS-1:0] pos_y,
  input  logic [FRAC_BITS-1:0] pos_z,
  output logic empty,
  input  logic pop,
  output logic signed [IMG_W-1:0] image_x,
  output logic signed [IMG_W-1:0] image_y,
  output logic signed [IMG_W-1:0] image_z,
  output logic in_main,
  output logic [IDX_W-1:0] particle_index,
  output logic last,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FRAC_BITS-1:0] cfg_data
);

  logic q_push, q_full, q_pop, q_empty;
  phf_entry_t q_wdata, q_rdata;

  // Classify particles
  phf_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_push(q_push), .q_full(q_full), .q_wdata(q_wdata)
  );

  // Decouple front from back
  phf_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
  );

  // Emit images
  phf_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_rdata(q_rdata), .q_pop(q_pop),
    .empty(empty), .pop(pop),
    .image_x(image_x), .image_y(image_y), .image_z(image_z),
    .in_main(in_main), .particle_index(particle_index), .last(last)
  );

endmodule

/* sv/phf_front.sv */
// Front end: config registers, particle counter, wrap and image classification.
module phf_front import phf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [FRAC_BITS-1:0] pos_x,
  input  logic [FRAC_BITS-1:0] pos_y,
  input  logic [FRAC_BITS-1:0] pos_z,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FRAC_BITS-1:0] cfg_data,
  output logic q_push,
  input  logic q_full,
  output phf_entry_t q_wdata
);

  function automatic logic signed [IMG_W-1:0] wrap_axis(input logic [FRAC_BITS-1:0] p,
                                                        input logic [FRAC_BITS-1:0] c);
    logic signed [IMG_W-1:0] d;
    d = signed'({2'b00, p}) - signed'({2'b00, c});
    if (d > HALF_S) begin
      d = d - ONE_S;
    end else if (d < -HALF_S) begin
      d = d + ONE_S;
    end
    return d;
  endfunction

  function automatic logic signed [IMG_W-1:0] shift_axis(input logic signed [IMG_W-1:0] d);
    return (d > 0) ? d - ONE_S : d + ONE_S;
  endfunction

  function automatic logic [IMG_W-1:0] mag(input logic signed [IMG_W-1:0] d);
    return d[IMG_W-1] ? IMG_W'(-d) : IMG_W'(d);
  endfunction

  logic [FRAC_BITS-1:0] center_x, center_y, center_z, half_width, half_total_width;
  logic [IDX_W-1:0] particle_counter;
  logic accept, advance;

  // Stage 1 registers: wrapped offsets
  logic s1_valid;
  logic signed [IMG_W-1:0] s1_dx, s1_dy, s1_dz;
  logic [IDX_W-1:0] s1_index;

  // Classification terms
  logic signed [IMG_W-1:0] sx, sy, sz;
  logic [IMG_W-1:0] htw_ext, hw_ext;
  logic okd_x, okd_y, okd_z, oks_x, oks_y, oks_z;
  logic main_hit, buf_hit;
  logic [N_IMG-1:0] img_mask, sel_mask;

  assign cfg_ready = 1'b1;
  assign advance = !s1_valid || !q_full;
  assign full = !advance;
  assign accept = push && advance;

  // Config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= HALF_U;
      center_y <= HALF_U;
      center_z <= HALF_U;
      half_width <= HALF_U;
      half_total_width <= HTW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        REG_CENTER_Z: center_z <= cfg_data;
        REG_HALF_W: half_width <= cfg_data;
        REG_HALF_TW: half_total_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // Running particle index, advances on every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      particle_counter <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        particle_counter <= particle_counter + IDX_W'(1);
      end
      if (advance) begin
        s1_valid <= push;
      end
    end
  end

  // Stage 1 payload: subtract center and wrap
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_dx <= wrap_axis(pos_x, center_x);
      s1_dy <= wrap_axis(pos_y, center_y);
      s1_dz <= wrap_axis(pos_z, center_z);
      s1_index <= particle_counter;
    end
  end

  // Main and buffer tests for unshifted and shifted axes
  always_comb begin
    htw_ext = {2'b00, half_total_width};
    hw_ext = {2'b00, half_width};
    sx = shift_axis(s1_dx);
    sy = shift_axis(s1_dy);
    sz = shift_axis(s1_dz);
    okd_x = mag(s1_dx) < htw_ext;
    okd_y = mag(s1_dy) < htw_ext;
    okd_z = mag(s1_dz) < htw_ext;
    oks_x = mag(sx) < htw_ext;
    oks_y = mag(sy) < htw_ext;
    oks_z = mag(sz) < htw_ext;
    main_hit = (mag(s1_dx) <= hw_ext) && (mag(s1_dy) <= hw_ext) && (mag(s1_dz) <= hw_ext);
    buf_hit = okd_x && okd_y && okd_z;
    for (int a = 0; a < N_IMG; a++) begin
      img_mask[a] = (SHIFT_X_SET[a] ? oks_x : okd_x) &&
                    (SHIFT_Y_SET[a] ? oks_y : okd_y) &&
                    (SHIFT_Z_SET[a] ? oks_z : okd_z);
    end
    if (main_hit) begin
      sel_mask = MASK_MAIN;
    end else if (buf_hit) begin
      sel_mask = img_mask;
    end else begin
      sel_mask = '0;
    end
  end

  // Particles with no result are dropped here
  assign q_push = s1_valid && !q_full && (sel_mask != '0);

  always_comb begin
    q_wdata.dx = s1_dx;
    q_wdata.dy = s1_dy;
    q_wdata.dz = s1_dz;
    q_wdata.sx = sx;
    q_wdata.sy = sy;
    q_wdata.sz = sz;
    q_wdata.in_main = main_hit;
    q_wdata.mask = sel_mask;
    q_wdata.index = s1_index;
  end

`ifndef SYNTHESIS
  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> particle_counter == $past(particle_counter) + IDX_W'(1))
    else $error("particle counter did not advance on accepted word");
  a_main_single: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_wdata.in_main) |-> q_wdata.mask == MASK_MAIN)
    else $error("main particle queued with more than one image");
`endif

endmodule

/* sv/phf_queue.sv */
// Short flop queue between front and back ends.
module phf_queue import phf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  phf_entry_t wdata,
  output logic full,
  input  logic pop,
  output logic empty,
  output phf_entry_t rdata
);

  phf_entry_t store [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic do_push, do_pop;

  assign full = count == Q_CNT_W'(Q_DEPTH);
  assign empty = count == '0;
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = store[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

endmodule

/* sv/phf_back.sv */
// Back end: walks the image mask of the head entry, one result word per cycle while popped.
module phf_back import phf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  phf_entry_t q_rdata,
  output logic q_pop,
  output logic empty,
  input  logic pop,
  output logic signed [IMG_W-1:0] image_x,
  output logic signed [IMG_W-1:0] image_y,
  output logic signed [IMG_W-1:0] image_z,
  output logic in_main,
  output logic [IDX_W-1:0] particle_index,
  output logic last
);

  logic [N_IMG-1:0] served;
  logic [N_IMG-1:0] remain, pick;
  logic pick_last, produce, out_valid;

  // Lowest pending image of the head entry
  assign remain = q_rdata.mask & ~served;
  assign pick = remain & (~remain + N_IMG'(1));
  assign pick_last = (remain & ~pick) == '0;
  assign produce = !q_empty && (!out_valid || pop);
  assign q_pop = produce && pick_last;
  assign empty = !out_valid;

  // Served images of the head entry and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      served <= '0;
      out_valid <= 1'b0;
    end else begin
      if (produce) begin
        served <= pick_last ? '0 : (served | pick);
      end
      if (produce) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (produce) begin
      image_x <= |(pick & SHIFT_X_SET) ? q_rdata.sx : q_rdata.dx;
      image_y <= |(pick & SHIFT_Y_SET) ? q_rdata.sy : q_rdata.dy;
      image_z <= |(pick & SHIFT_Z_SET) ? q_rdata.sz : q_rdata.dz;
      in_main <= q_rdata.in_main;
      particle_index <= q_rdata.index;
      last <= pick_last;
    end
  end

`ifndef SYNTHESIS
  a_pending: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> remain != '0)
    else $error("head entry has no pending image");
  a_hold_head: assert property (@(posedge clk) disable iff (rst)
    (produce && !pick_last) |=> !q_empty && served != '0)
    else $error("head entry lost before its last image");
`endif

endmodule

/* tb/periodic_subregion_halo_filter_test.sv */
// Self-checking testbench for the periodic subregion halo filter.
`timescale 1ns / 100ps

module periodic_subregion_halo_filter_test;
  import phf_pkg::*;

  // Fixed-point constants of the prediction
  localparam longint ONE_FX = longint'(1) << FRAC_BITS;
  localparam longint HALF_FX = longint'(1) << (FRAC_BITS - 1);
  localparam logic [FRAC_BITS-1:0] ALL_ONES = {FRAC_BITS{1'b1}};
  localparam logic [FRAC_BITS-1:0] HALF_POS = FRAC_BITS'(HALF_FX);
  // Register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_MID = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int SWEEP_PHASES = 7;
  localparam int SWEEP_ITEMS = 60;
  localparam int FLOOD_ITEMS = 40;

  // One expected result word
  typedef struct {
    logic signed [IMG_W-1:0] x;
    logic signed [IMG_W-1:0] y;
    logic signed [IMG_W-1:0] z;
    logic main;
    logic [IDX_W-1:0] index;
    logic last;
  } halo_word_t;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic [FRAC_BITS-1:0] pos_x;
  logic [FRAC_BITS-1:0] pos_y;
  logic [FRAC_BITS-1:0] pos_z;
  logic empty;
  logic pop;
  logic signed [IMG_W-1:0] image_x;
  logic signed [IMG_W-1:0] image_y;
  logic signed [IMG_W-1:0] image_z;
  logic in_main;
  logic [IDX_W-1:0] particle_index;
  logic last;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FRAC_BITS-1:0] cfg_data;

  periodic_subregion_halo_filter dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pos_z(pos_z),
    .empty(empty),
    .pop(pop),
    .image_x(image_x),
    .image_y(image_y),
    .image_z(image_z),
    .in_main(in_main),
    .particle_index(particle_index),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the block's registers and particle counter
  logic [FRAC_BITS-1:0] model_center [3];
  logic [FRAC_BITS-1:0] model_hw;
  logic [FRAC_BITS-1:0] model_htw;
  logic [IDX_W-1:0] particle_count;

  halo_word_t halo_expected [$];

  int errors = 0;
  int particles_sent = 0;
  int words_checked = 0;
  int reg_writes = 0;
  int max_burst = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_request = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Periodic wrap of one axis into [-1/2, 1/2]
  function automatic longint wrap_offset(input logic [FRAC_BITS-1:0] p,
                                         input logic [FRAC_BITS-1:0] c);
    longint d;
    d = longint'(p) - longint'(c);
    if (d > HALF_FX) d = d - ONE_FX;
    if (d < -HALF_FX) d = d + ONE_FX;
    return d;
  endfunction

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Move an offset to its periodic image on the other side
  function automatic longint fold_image(input longint d);
    return (d > 0) ? d - ONE_FX : d + ONE_FX;
  endfunction

  // Classify one particle and queue the words it should produce
  function automatic void predict_particle(input logic [FRAC_BITS-1:0] px,
                                           input logic [FRAC_BITS-1:0] py,
                                           input logic [FRAC_BITS-1:0] pz);
    logic [FRAC_BITS-1:0] p [3];
    longint d [3];
    longint img [3];
    halo_word_t burst [N_IMG];
    bit inside_main;
    bit inside_buf;
    int n;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    inside_main = 1'b1;
    inside_buf = 1'b1;
    n = 0;
    for (int a = 0; a < 3; a++) begin
      d[a] = wrap_offset(p[a], model_center[a]);
      if (!(magnitude(d[a]) < longint'(model_htw))) inside_buf = 1'b0;
      if (!(magnitude(d[a]) <= longint'(model_hw))) inside_main = 1'b0;
    end
    if (inside_main) begin
      burst[0].x = d[0][IMG_W-1:0];
      burst[0].y = d[1][IMG_W-1:0];
      burst[0].z = d[2][IMG_W-1:0];
      burst[0].main = 1'b1;
      burst[0].index = particle_count;
      burst[0].last = 1'b0;
      n = 1;
    end else if (inside_buf) begin
      // x slowest, z fastest, unshifted image first
      for (int k = 0; k < N_IMG; k++) begin
        img[0] = ((k & 4) != 0) ? fold_image(d[0]) : d[0];
        img[1] = ((k & 2) != 0) ? fold_image(d[1]) : d[1];
        img[2] = ((k & 1) != 0) ? fold_image(d[2]) : d[2];
        if (magnitude(img[0]) < longint'(model_htw) &&
            magnitude(img[1]) < longint'(model_htw) &&
            magnitude(img[2]) < longint'(model_htw)) begin
          burst[n].x = img[0][IMG_W-1:0];
          burst[n].y = img[1][IMG_W-1:0];
          burst[n].z = img[2][IMG_W-1:0];
          burst[n].main = 1'b0;
          burst[n].index = particle_count;
          burst[n].last = 1'b0;
          n++;
        end
      end
    end
    if (n > 0) burst[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) halo_expected.push_back(burst[k]);
    if (n > max_burst) max_burst = n;
    particle_count = particle_count + IDX_W'(1);
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Position at a signed offset from a center, wrapped to the box
  function automatic logic [FRAC_BITS-1:0] at_offset(input logic [FRAC_BITS-1:0] c,
                                                     input longint d);
    longint p;
    p = longint'(c) + d;
    return p[FRAC_BITS-1:0];
  endfunction

  // Random axis value, biased toward the cube faces
  function automatic logic [FRAC_BITS-1:0] near_face(input logic [FRAC_BITS-1:0] c);
    int r;
    longint d;
    r = $urandom_range(0, 99);
    if (r < 20) return FRAC_BITS'($urandom());
    if (r < 45) d = longint'(model_hw);
    else if (r < 75) d = longint'(model_htw);
    else if (r < 85) d = HALF_FX;
    else d = longint'($urandom_range(0, int'(model_hw)));
    d = d + longint'($urandom_range(0, 6)) - 3;
    if ($urandom_range(0, 1) == 1) d = -d;
    return at_offset(c, d);
  endfunction

  // Offer one particle and wait until the block takes it
  task automatic send_particle(input logic [FRAC_BITS-1:0] px,
                               input logic [FRAC_BITS-1:0] py,
                               input logic [FRAC_BITS-1:0] pz);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_particle(px, py, pz);
    particles_sent++;
  endtask

  // Stop offering, let every expected word drain, then let the pipe go quiet
  task automatic settle_idle();
    push <= 1'b0;
    while (halo_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; only called while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [FRAC_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CENTER_X: model_center[0] = data;
      REG_CENTER_Y: model_center[1] = data;
      REG_CENTER_Z: model_center[2] = data;
      REG_HALF_W: model_hw = data;
      REG_HALF_TW: model_htw = data;
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [FRAC_BITS-1:0] cx, input logic [FRAC_BITS-1:0] cy,
                           input logic [FRAC_BITS-1:0] cz, input logic [FRAC_BITS-1:0] hw,
                           input logic [FRAC_BITS-1:0] htw);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_HALF_W, hw);
    write_reg(REG_HALF_TW, htw);
  endtask

  // Particles against the reset configuration, box corners included
  task automatic test_reset_state();
    send_particle(HALF_POS, HALF_POS, HALF_POS);
    send_particle('0, '0, '0);
    send_particle(ALL_ONES, ALL_ONES, ALL_ONES);
    send_particle('0, ALL_ONES, HALF_POS);
    settle_idle();
  endtask

  // Writes past the register list must leave the configuration alone
  task automatic test_spare_indexes();
    write_reg(REG_SPARE_LO, ALL_ONES);
    write_reg(REG_SPARE_MID, '0);
    write_reg(REG_SPARE_HI, ALL_ONES);
    send_particle(24'h000001, 24'hFFFFFE, 24'h7FFFFF);
    settle_idle();
  endtask

  // Inclusive main face, exclusive buffer face
  task automatic test_cube_faces();
    longint hw;
    longint htw;
    hw = 64'h100000;
    htw = 64'h180000;
    write_all(24'h400000, 24'hC00000, 24'h123456, hw[FRAC_BITS-1:0], htw[FRAC_BITS-1:0]);
    send_particle(at_offset(model_center[0], hw), at_offset(model_center[1], -hw),
                  model_center[2]);
    send_particle(at_offset(model_center[0], hw + 1), model_center[1], model_center[2]);
    send_particle(at_offset(model_center[0], htw - 1), at_offset(model_center[1], 1 - htw),
                  at_offset(model_center[2], -hw - 1));
    send_particle(at_offset(model_center[0], htw), model_center[1], model_center[2]);
    settle_idle();
  endtask

  // A zero buffer width empties its cube, a zero main width keeps only the center; a main particle wins over the buffer
  task automatic test_degenerate_widths();
    write_all(24'h2AAAAA, 24'h555555, 24'hFFFFFF, '0, '0);
    send_particle(model_center[0], model_center[1], model_center[2]);
    send_particle(at_offset(model_center[0], 1), model_center[1], model_center[2]);
    settle_idle();
    write_reg(REG_HALF_W, 24'h300000);
    write_reg(REG_HALF_TW, 24'h100000);
    send_particle(at_offset(model_center[0], 64'h200000), model_center[1],
                  at_offset(model_center[2], -64'h300000));
    send_particle(at_offset(model_center[0], 64'h300001), model_center[1], model_center[2]);
    settle_idle();
  endtask

  // Half-box offsets with a buffer just past 1/2 give every periodic image
  task automatic test_image_bursts();
    write_all('0, '0, '0, '0, HALF_POS + FRAC_BITS'(1));
    send_particle(HALF_POS, HALF_POS, HALF_POS);
    send_particle(HALF_POS, HALF_POS, '0);
    send_particle(ALL_ONES, '0, 24'h000001);
    settle_idle();
    // wrap from either end of the box
    write_reg(REG_CENTER_X, ALL_ONES);
    send_particle('0, ALL_ONES, HALF_POS);
    settle_idle();
    // widths at one half and at all ones
    write_reg(REG_HALF_W, HALF_POS);
    write_reg(REG_HALF_TW, ALL_ONES);
    send_particle(24'h123456, 24'hFEDCBA, 24'h800001);
    settle_idle();
    write_reg(REG_HALF_W, ALL_ONES);
    send_particle(24'h7FFFFF, '0, ALL_ONES);
    settle_idle();
  endtask

  // Random configurations, particles mostly near the cube faces
  task automatic test_random_sweeps();
    logic [FRAC_BITS-1:0] c [3];
    logic [FRAC_BITS-1:0] hw;
    logic [FRAC_BITS-1:0] htw;
    int r;
    for (int p = 0; p < SWEEP_PHASES; p++) begin
      for (int a = 0; a < 3; a++) begin
        r = $urandom_range(0, 9);
        c[a] = (r == 0) ? '0 : (r == 1) ? ALL_ONES : FRAC_BITS'($urandom());
      end
      r = $urandom_range(0, 19);
      if (r < 2) hw = '0;
      else if (r < 4) hw = HALF_POS;
      else if (r == 4) hw = ALL_ONES;
      else hw = FRAC_BITS'($urandom_range(32'h10000, 32'h400000));
      r = $urandom_range(0, 9);
      if (r == 0) htw = '0;
      else if (r == 1) htw = ALL_ONES;
      else if (r == 2) htw = FRAC_BITS'($urandom_range(0, int'(hw)));
      else htw = hw + FRAC_BITS'($urandom_range(1, 32'h200000));
      write_all(c[0], c[1], c[2], hw, htw);
      if ($urandom_range(0, 1) == 1)
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_SPARE_LO), int'(REG_SPARE_HI))),
                  FRAC_BITS'($urandom()));
      tx_idle_on = !(p == 1 || p == 3);
      rx_idle_on = !(p == 2 || p == 3);
      for (int i = 0; i < SWEEP_ITEMS; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_particle(FRAC_BITS'($urandom()), FRAC_BITS'($urandom()),
                        FRAC_BITS'($urandom()));
        else
          send_particle(near_face(c[0]), near_face(c[1]), near_face(c[2]));
      end
      settle_idle();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Receiver holds off while the sender keeps pushing, so full must rise
  task automatic test_backpressure();
    write_all(FRAC_BITS'($urandom()), FRAC_BITS'($urandom()), FRAC_BITS'($urandom()),
              HALF_POS, HTW_RST);
    tx_idle_on = 1'b0;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < FLOOD_ITEMS; i++)
      send_particle(FRAC_BITS'($urandom()), FRAC_BITS'($urandom()), FRAC_BITS'($urandom()));
    tx_idle_on = 1'b1;
    settle_idle();
  endtask

  // Stimulus sequence
  initial begin
    rst = 1'b1;
    push = 1'b0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int a = 0; a < 3; a++) model_center[a] = HALF_POS;
    model_hw = HALF_POS;
    model_htw = FRAC_BITS'(HALF_FX + ONE_FX / 10);
    particle_count = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_spare_indexes();
    test_cube_faces();
    test_degenerate_widths();
    test_image_bursts();
    test_random_sweeps();
    test_backpressure();
    settle_idle();
    if (halo_expected.size() != 0) begin
      errors++;
      $display("%0t: %0d expected words never arrived", $time, halo_expected.size());
    end
    $display("Covered %0d particles and %0d register writes; %0d result words checked.",
             particles_sent, reg_writes, words_checked);
    $display("Longest image burst %0d words; receiver held off %0d cycles to fill the block.",
             max_burst, HOLD_CYCLES);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: random pop gaps plus the long hold on request
  initial begin : drive_pop
    int stall_left;
    int g;
    stall_left = 0;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (hold_request > 0) begin
        stall_left = hold_request - 1;
        hold_request = 0;
        pop <= 1'b0;
      end else begin
        g = rx_idle_on ? pick_gap() : 0;
        if (g > 0) begin
          stall_left = g - 1;
          pop <= 1'b0;
        end else begin
          pop <= 1'b1;
        end
      end
    end
  end

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin : check_words
    halo_word_t want;
    if (!rst && pop && !empty) begin
      if (halo_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, got x=%0d y=%0d z=%0d main=%0b idx=%0d last=%0b",
                 $time, image_x, image_y, image_z, in_main, particle_index, last);
      end else begin
        want = halo_expected.pop_front();
        words_checked++;
        if (image_x !== want.x || image_y !== want.y || image_z !== want.z ||
            in_main !== want.main || particle_index !== want.index || last !== want.last) begin
          errors++;
          $display("%0t: mismatch, expected x=%0d y=%0d z=%0d main=%0b idx=%0d last=%0b",
                   $time, want.x, want.y, want.z, want.main, want.index, want.last);
          $display("%0t:           got x=%0d y=%0d z=%0d main=%0b idx=%0d last=%0b",
                   $time, image_x, image_y, image_z, in_main, particle_index, last);
        end
      end
    end
  end

  // Watchdog: end the run when no handshake completes for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || rst)
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles, %0d words still expected",
             $time, STALL_LIMIT, halo_expected.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* periodic_subregion_halo_filter.f */
sv/phf_pkg.sv
sv/phf_front.sv
sv/phf_queue.sv
sv/phf_back.sv
sv/periodic_subregion_halo_filter.sv
tb/periodic_subregion_halo_filter_test.sv
